### design/apr_pkg.sv
// Shared types, constants and arithmetic helpers of the adaptive predictive regulator.
package apr_pkg;

	// Payload and storage types.
	typedef logic signed [24:0] angle_t;
	typedef logic signed [24:0] drive_t;
	typedef logic signed [25:0] yval_t;
	typedef logic signed [31:0] param_t;
	typedef logic signed [69:0] prod_t;
	typedef logic [2:0] cfg_idx_t;
	typedef logic [31:0] cfg_data_t;
	typedef logic [23:0] drive_mag_t;

	// Configuration register indexes.
	localparam cfg_idx_t REG_MAX_DRIVE = 3'd0;
	localparam cfg_idx_t REG_INIT_A1 = 3'd1;
	localparam cfg_idx_t REG_INIT_A2 = 3'd2;
	localparam cfg_idx_t REG_INIT_B1 = 3'd3;
	localparam cfg_idx_t REG_INIT_B2 = 3'd4;
	localparam cfg_idx_t REG_INIT_B3 = 3'd5;

	// Reset values of the configuration registers.
	localparam drive_mag_t RST_MAX_DRIVE = 24'd2097152;
	localparam param_t RST_INIT_A1 = 32'sd8220836;
	localparam param_t RST_INIT_A2 = 32'sd8220836;
	localparam param_t RST_INIT_B1 = 32'sd855638;
	localparam param_t RST_INIT_B2 = 32'sd687866;
	localparam param_t RST_INIT_B3 = 32'sd184549;

	// Fixed-point constants.
	localparam yval_t Q16_180 = 26'sd11796480;
	localparam logic signed [36:0] NOISE_LEVEL = 37'sd13;
	localparam logic signed [32:0] GAIN_A = 33'sd26214;
	localparam logic signed [32:0] GAIN_B = 33'sd13107;
	localparam logic signed [32:0] REF_C0 = 33'sd4004721;
	localparam logic signed [32:0] REF_C1 = 33'sd1400344;
	localparam logic signed [32:0] REF_C2 = 33'sd14172838;
	localparam logic [34:0] ONE_Q16 = 35'd65536;

	// Divider widths: dividend and quotient, divisor, cycle counter.
	localparam int DVD_W = 67;
	localparam int DVS_W = 35;
	localparam int CNT_W = 7;

	// Saturate a wide signed value to 32 bits.
	function automatic param_t sat32(input logic signed [69:0] v);
		if (v > 70'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -70'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Round half up and drop 24 fraction bits.
	function automatic logic signed [45:0] rnd24(input prod_t p);
		prod_t t;
		t = p + 70'sd8388608;
		return t[69:24];
	endfunction

	// Round half up and drop 16 fraction bits.
	function automatic logic signed [53:0] rnd16(input prod_t p);
		prod_t t;
		t = p + 70'sd32768;
		return t[69:16];
	endfunction

endpackage

### design/adaptive_predictive_regulator.sv
// Top level: sequencer around one shared multiplier and one restoring divider.
// The bit-serial divider runs once per parameter update and once for the drive, unless
// the horizon sum is zero; each product of the multiplier is registered before use.
// Throughput: one item at a time; the input is ready again once the result is registered.
// Reset (arst_n low) loads the configuration defaults, the model parameters and histories.
module adaptive_predictive_regulator_core #(
	parameter int HORIZON = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  apr_pkg::cfg_idx_t  cfg_index,
	input  apr_pkg::cfg_data_t cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  apr_pkg::angle_t    measured_angle,
	input  apr_pkg::angle_t    setpoint,
	input  logic              restart,
	output logic              out_valid,
	input  logic              out_ready,
	output apr_pkg::drive_t    drive,
	output logic              adapting,
	output logic              clamped
);
	import apr_pkg::*;

	localparam int JW = $clog2(HORIZON);

	// Sequencer states.
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL   = 4'd1;
	localparam logic [3:0] ST_ACT   = 4'd2;
	localparam logic [3:0] ST_EK    = 4'd3;
	localparam logic [3:0] ST_DIV   = 4'd4;
	localparam logic [3:0] ST_PSW   = 4'd5;
	localparam logic [3:0] ST_HINIT = 4'd6;
	localparam logic [3:0] ST_DRV   = 4'd7;
	localparam logic [3:0] ST_CLAMP = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;

	// Multiplier operation groups.
	localparam logic [3:0] OP_YEST = 4'd0;
	localparam logic [3:0] OP_SQ   = 4'd1;
	localparam logic [3:0] OP_DA   = 4'd2;
	localparam logic [3:0] OP_DB   = 4'd3;
	localparam logic [3:0] OP_GA   = 4'd4;
	localparam logic [3:0] OP_GB   = 4'd5;
	localparam logic [3:0] OP_PS   = 4'd6;
	localparam logic [3:0] OP_REF  = 4'd7;
	localparam logic [3:0] OP_HOR  = 4'd8;
	localparam logic [3:0] OP_NUM  = 4'd9;

	logic [3:0] state_q;
	logic [3:0] op_q;
	logic [2:0] ki_q;
	logic [JW-1:0] j_q;

	// Configuration and model state.
	drive_mag_t max_drive_q;
	param_t init_q [0:4];
	param_t t_q [0:4];
	yval_t yh0_q, yh1_q;
	drive_t uh_q [0:3];
	angle_t prev_q;

	// Working registers of one item.
	angle_t yp_q, sp_q;
	logic signed [63:0] acc_q;
	logic signed [36:0] ek_q, ga_q, gb_q;
	logic adapt_q;
	logic [34:0] sy_q, su_q, d_q;
	param_t p_q, ce1_q, ce2_q, cg1_q, cg2_q, cg3_q;
	logic signed [35:0] h_q;
	prod_t prod_s1;
	drive_t u0_q;
	logic clp_q;

	// Divider registers.
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic div_neg_q;

	// Output register.
	logic out_valid_q;
	drive_t drive_q;
	logic adapting_q, clamped_q;

	// Combinational helpers.
	yval_t y0_w;
	logic signed [32:0] sig_w;
	logic signed [36:0] mul_a;
	logic signed [32:0] mul_b;
	prod_t prod_w;
	logic signed [36:0] ek_w;
	logic signed [45:0] r24_w;
	logic signed [63:0] r24x_w;
	prod_t pmag_w;
	logic signed [63:0] nmag_w;
	logic signed [35:0] hmag_w;
	logic signed [69:0] qs_w;
	logic [DVS_W:0] rem_sh_w;
	logic [DVS_W+1:0] diff_w;
	logic [2:0] hsel_w;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign drive = drive_q;
	assign adapting = adapting_q;
	assign clamped = clamped_q;

	assign y0_w = 26'(yp_q) + Q16_180;
	assign ek_w = 37'(y0_w) - acc_q[36:0];
	assign r24_w = rnd24(prod_s1);
	assign r24x_w = 64'(r24_w);
	assign pmag_w = prod_s1[69] ? -prod_s1 : prod_s1;
	assign nmag_w = acc_q[63] ? -acc_q : acc_q;
	assign hmag_w = h_q[35] ? -h_q : h_q;
	assign qs_w = div_neg_q ? -signed'({3'b000, dvd_q}) : signed'({3'b000, dvd_q});
	assign rem_sh_w = {rem_q, dvd_q[DVD_W-1]};
	assign diff_w = {1'b0, rem_sh_w} - {2'b00, dvs_q};
	assign prod_w = mul_a * mul_b;

	// History signal of slot k: y1, y2, u2, u3, u4.
	always_comb begin
		case (ki_q)
			3'd0: sig_w = 33'(yh0_q);
			3'd1: sig_w = 33'(yh1_q);
			3'd2: sig_w = 33'(uh_q[1]);
			3'd3: sig_w = 33'(uh_q[2]);
			3'd4: sig_w = 33'(uh_q[3]);
			default: sig_w = '0;
		endcase
	end

	// Parameter used in horizon slot k: g1, g2, g3, e1, e2 take b1, b2, b3, a1, a2.
	always_comb begin
		case (ki_q)
			3'd0: hsel_w = 3'd2;
			3'd1: hsel_w = 3'd3;
			3'd2: hsel_w = 3'd4;
			3'd3: hsel_w = 3'd0;
			3'd4: hsel_w = 3'd1;
			default: hsel_w = 3'd0;
		endcase
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			OP_YEST: begin
				mul_a = 37'(t_q[ki_q]);
				mul_b = sig_w;
			end
			OP_SQ: begin
				mul_a = 37'(sig_w);
				mul_b = sig_w;
			end
			OP_DA: begin
				mul_a = signed'({2'b00, sy_q});
				mul_b = GAIN_A;
			end
			OP_DB: begin
				mul_a = signed'({2'b00, su_q});
				mul_b = GAIN_B;
			end
			OP_GA: begin
				mul_a = ek_q;
				mul_b = GAIN_A;
			end
			OP_GB: begin
				mul_a = ek_q;
				mul_b = GAIN_B;
			end
			OP_PS: begin
				mul_a = (ki_q < 3'd2) ? ga_q : gb_q;
				mul_b = sig_w;
			end
			OP_REF: begin
				case (ki_q)
					3'd0: begin
						mul_a = 37'(yp_q);
						mul_b = REF_C0;
					end
					3'd1: begin
						mul_a = 37'(prev_q);
						mul_b = REF_C1;
					end
					default: begin
						mul_a = 37'(sp_q);
						mul_b = REF_C2;
					end
				endcase
			end
			OP_HOR: begin
				mul_a = 37'(p_q);
				mul_b = 33'(t_q[hsel_w]);
			end
			OP_NUM: begin
				case (ki_q)
					3'd0: begin
						mul_a = 37'(ce1_q);
						mul_b = 33'(y0_w);
					end
					3'd1: begin
						mul_a = 37'(ce2_q);
						mul_b = 33'(yh0_q);
					end
					3'd2: begin
						mul_a = 37'(cg2_q);
						mul_b = 33'(uh_q[0]);
					end
					default: begin
						mul_a = 37'(cg3_q);
						mul_b = 33'(uh_q[1]);
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_drive_q <= RST_MAX_DRIVE;
			init_q[0] <= RST_INIT_A1;
			init_q[1] <= RST_INIT_A2;
			init_q[2] <= RST_INIT_B1;
			init_q[3] <= RST_INIT_B2;
			init_q[4] <= RST_INIT_B3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_DRIVE: max_drive_q <= cfg_data[23:0];
				REG_INIT_A1: init_q[0] <= cfg_data;
				REG_INIT_A2: init_q[1] <= cfg_data;
				REG_INIT_B1: init_q[2] <= cfg_data;
				REG_INIT_B2: init_q[3] <= cfg_data;
				REG_INIT_B3: init_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer, datapath and model state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_YEST;
			ki_q <= '0;
			j_q <= '0;
			t_q[0] <= RST_INIT_A1;
			t_q[1] <= RST_INIT_A2;
			t_q[2] <= RST_INIT_B1;
			t_q[3] <= RST_INIT_B2;
			t_q[4] <= RST_INIT_B3;
			yh0_q <= Q16_180;
			yh1_q <= Q16_180;
			for (int i = 0; i < 4; i++) begin
				uh_q[i] <= '0;
			end
			prev_q <= '0;
			out_valid_q <= 1'b0;
			drive_q <= '0;
			adapting_q <= 1'b0;
			clamped_q <= 1'b0;
			yp_q <= '0;
			sp_q <= '0;
			acc_q <= '0;
			ek_q <= '0;
			ga_q <= '0;
			gb_q <= '0;
			adapt_q <= 1'b0;
			sy_q <= '0;
			su_q <= '0;
			d_q <= '0;
			p_q <= '0;
			ce1_q <= '0;
			ce2_q <= '0;
			cg1_q <= '0;
			cg2_q <= '0;
			cg3_q <= '0;
			h_q <= '0;
			prod_s1 <= '0;
			u0_q <= '0;
			clp_q <= 1'b0;
			dvd_q <= '0;
			dvs_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			div_neg_q <= 1'b0;
		end else begin
			// The result leaves on its output transaction; retiring an item refills it instead.
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						yp_q <= measured_angle;
						sp_q <= setpoint;
						if (restart) begin
							for (int i = 0; i < 5; i++) begin
								t_q[i] <= init_q[i];
							end
							yh0_q <= Q16_180;
							yh1_q <= Q16_180;
							for (int i = 0; i < 4; i++) begin
								uh_q[i] <= '0;
							end
							prev_q <= '0;
						end
						op_q <= OP_YEST;
						ki_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_s1 <= prod_w;
					state_q <= ST_ACT;
				end
				ST_ACT: begin
					state_q <= ST_MUL;
					ki_q <= ki_q + 3'd1;
					case (op_q)
						OP_YEST: begin
							acc_q <= ((ki_q == 3'd0) ? 64'sd0 : acc_q) + r24x_w;
							if (ki_q == 3'd4) begin
								state_q <= ST_EK;
							end
						end
						OP_SQ: begin
							if (ki_q < 3'd2) begin
								sy_q <= sy_q + prod_s1[50:16];
							end else begin
								su_q <= su_q + prod_s1[50:16];
							end
							if (ki_q == 3'd4) begin
								op_q <= OP_DA;
							end
						end
						OP_DA: begin
							d_q <= ONE_Q16 + prod_s1[50:16];
							op_q <= OP_DB;
						end
						OP_DB: begin
							d_q <= d_q + prod_s1[50:16];
							op_q <= OP_GA;
						end
						OP_GA: begin
							ga_q <= 37'(rnd16(prod_s1));
							op_q <= OP_GB;
						end
						OP_GB: begin
							gb_q <= 37'(rnd16(prod_s1));
							op_q <= OP_PS;
							ki_q <= '0;
						end
						OP_PS: begin
							// Start |g*x| * 2^8 / D; the sign of the product is the step's sign.
							dvd_q <= DVD_W'({pmag_w, 8'h00});
							dvs_q <= d_q;
							rem_q <= '0;
							cnt_q <= '0;
							div_neg_q <= prod_s1[69];
							ki_q <= ki_q;
							state_q <= ST_DIV;
						end
						OP_REF: begin
							if (ki_q == 3'd0) begin
								acc_q <= 64'(prod_s1);
							end else if (ki_q == 3'd1) begin
								acc_q <= acc_q - 64'(prod_s1);
							end else begin
								acc_q <= 64'(rnd24(70'(acc_q) + prod_s1)) + 64'(Q16_180);
								state_q <= ST_HINIT;
							end
						end
						OP_HOR: begin
							case (ki_q)
								3'd0: cg1_q <= sat32(70'(r24_w) + 70'(cg2_q));
								3'd1: cg2_q <= sat32(70'(r24_w) + 70'(cg3_q));
								3'd2: cg3_q <= sat32(70'(r24_w));
								3'd3: ce1_q <= sat32(70'(r24_w) + 70'(ce2_q));
								default: begin
									ce2_q <= sat32(70'(r24_w));
									h_q <= h_q + 36'(cg1_q);
									p_q <= ce1_q;
									ki_q <= '0;
									if (j_q == JW'(HORIZON - 1)) begin
										op_q <= OP_NUM;
									end else begin
										j_q <= j_q + 1'b1;
									end
								end
							endcase
						end
						OP_NUM: begin
							acc_q <= acc_q - r24x_w;
							if (ki_q == 3'd3) begin
								state_q <= ST_DRV;
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_EK: begin
					ek_q <= ek_w;
					ki_q <= '0;
					state_q <= ST_MUL;
					if ((ek_w > NOISE_LEVEL) || (ek_w < -NOISE_LEVEL)) begin
						adapt_q <= 1'b1;
						sy_q <= '0;
						su_q <= '0;
						op_q <= OP_SQ;
					end else begin
						adapt_q <= 1'b0;
						op_q <= OP_REF;
					end
				end
				ST_DIV: begin
					// One quotient bit per cycle.
					if (!diff_w[DVS_W+1]) begin
						rem_q <= diff_w[DVS_W-1:0];
						dvd_q <= {dvd_q[DVD_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh_w[DVS_W-1:0];
						dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DVD_W - 1)) begin
						state_q <= (op_q == OP_PS) ? ST_PSW : ST_CLAMP;
					end
				end
				ST_PSW: begin
					t_q[ki_q] <= sat32(70'(t_q[ki_q]) + qs_w);
					state_q <= ST_MUL;
					if (ki_q == 3'd4) begin
						op_q <= OP_REF;
						ki_q <= '0;
					end else begin
						ki_q <= ki_q + 3'd1;
					end
				end
				ST_HINIT: begin
					ce1_q <= t_q[0];
					ce2_q <= t_q[1];
					cg1_q <= t_q[2];
					cg2_q <= t_q[3];
					cg3_q <= t_q[4];
					h_q <= 36'(t_q[2]);
					p_q <= t_q[0];
					j_q <= JW'(1);
					ki_q <= '0;
					op_q <= OP_HOR;
					state_q <= ST_MUL;
				end
				ST_DRV: begin
					if (h_q == 36'sd0) begin
						// Zero horizon sum: saturate by the numerator's sign.
						if (acc_q > 64'sd0) begin
							u0_q <= signed'({1'b0, max_drive_q});
							clp_q <= 1'b1;
						end else if (acc_q < 64'sd0) begin
							u0_q <= -signed'({1'b0, max_drive_q});
							clp_q <= 1'b1;
						end else begin
							u0_q <= '0;
							clp_q <= 1'b0;
						end
						state_q <= ST_FIN;
					end else begin
						dvd_q <= DVD_W'({nmag_w, 24'h000000});
						dvs_q <= hmag_w[DVS_W-1:0];
						rem_q <= '0;
						cnt_q <= '0;
						div_neg_q <= acc_q[63] ^ h_q[35];
						state_q <= ST_DIV;
					end
				end
				ST_CLAMP: begin
					if (dvd_q > DVD_W'(max_drive_q)) begin
						u0_q <= div_neg_q ? -signed'({1'b0, max_drive_q})
							: signed'({1'b0, max_drive_q});
						clp_q <= 1'b1;
					end else begin
						u0_q <= div_neg_q ? -signed'(dvd_q[24:0]) : signed'(dvd_q[24:0]);
						clp_q <= 1'b0;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// Wait for the output register, then retire the item.
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						drive_q <= u0_q;
						adapting_q <= adapt_q;
						clamped_q <= clp_q;
						yh1_q <= yh0_q;
						yh0_q <= y0_w;
						uh_q[3] <= uh_q[2];
						uh_q[2] <= uh_q[1];
						uh_q[1] <= uh_q[0];
						uh_q[0] <= u0_q;
						prev_q <= yp_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### design/apr_checker.sv
// Port-level checker for the regulator core and its bind statement.
module apr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input apr_pkg::drive_t drive,
	input logic           adapting,
	input logic           clamped
);

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(adapting)
			&& $stable(clamped))
		else $error("stalled result changed");

	// An accepted item makes the block busy and takes input ready low.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input ready too soon after a transaction");

	// While idle, no new result follows right after one is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && in_ready |=> !out_valid)
		else $error("extra result after output transaction");

	// A new result only appears at the end of a busy period.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work in progress");

endmodule

bind adaptive_predictive_regulator_core apr_checker u_apr_checker (.*);

### sim/tb_adaptive_predictive_regulator_core.sv
// Self-checking testbench of the adaptive predictive regulator core.
`timescale 1ns / 1ps

module tb_adaptive_predictive_regulator_core;
	import apr_pkg::*;

	// Register indexes that map to no register; writes to them are ignored.
	localparam cfg_idx_t REG_UNMAPPED_LO = 3'd6;
	localparam cfg_idx_t REG_UNMAPPED_HI = 3'd7;
	localparam longint ANGLE_MAX = 64'sd11796480;
	localparam longint OFFSET_180 = 64'sd11796480;

	typedef struct {
		drive_t drive;
		bit     adapting;
		bit     clamped;
	} ctrl_out_t;

	// One directed row; the typed-in result is used only where has_out is set.
	typedef struct {
		longint angle;
		longint target;
		bit     rst;
		bit     has_out;
		longint drive;
		bit     adapting;
		bit     clamped;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	cfg_idx_t cfg_index;
	cfg_data_t cfg_data;
	logic in_valid;
	logic in_ready;
	angle_t measured_angle;
	angle_t setpoint;
	logic restart;
	logic out_valid;
	logic out_ready;
	drive_t drive;
	logic adapting;
	logic clamped;

	adaptive_predictive_regulator_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .measured_angle(measured_angle),
		.setpoint(setpoint), .restart(restart),
		.out_valid(out_valid), .out_ready(out_ready), .drive(drive),
		.adapting(adapting), .clamped(clamped)
	);

	// Shadow copy of the configuration and of the regulator state.
	longint lim_drive;
	longint seed_par[5];
	longint est_par[5];
	longint ang_hist[2];
	longint drv_hist[4];
	longint last_angle;

	ctrl_out_t expected_q[$];
	int err_count;
	int send_idle_pct;
	int recv_stall_pct;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog.
	initial begin
		#150_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint round_drop(longint v, int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	// Normalized gradient term g*x/d to Q8.24, truncated toward zero.
	function automatic longint grad_term(longint g, longint x, longint unsigned d);
		bit neg;
		longint unsigned mag, qi, r;
		longint res;
		neg = (g < 0) != (x < 0);
		mag = longint'(g < 0 ? -g : g) * longint'(x < 0 ? -x : x);
		qi = mag / d;
		r = mag % d;
		res = longint'((qi << 8) + ((r << 8) / d));
		return neg ? -res : res;
	endfunction

	function automatic void reload_state();
		for (int i = 0; i < 5; i++) est_par[i] = seed_par[i];
		ang_hist[0] = OFFSET_180;
		ang_hist[1] = OFFSET_180;
		for (int i = 0; i < 4; i++) drv_hist[i] = 0;
		last_angle = 0;
	endfunction

	function automatic void apply_cfg(cfg_idx_t idx, cfg_data_t val);
		if (idx == REG_MAX_DRIVE) begin
			lim_drive = longint'(val[23:0]);
		end else if (idx >= REG_INIT_A1 && idx <= REG_INIT_B3) begin
			seed_par[idx - REG_INIT_A1] = longint'(param_t'(val));
		end
	endfunction

	// One period: adapt on a large error, expand the horizon, divide and clamp.
	function automatic ctrl_out_t regulate(longint yp, longint sp, bit rst);
		ctrl_out_t res;
		longint y0, y1, y2, u1, u2, u3, u4, yest, ek, ydk, ga, gb, h, num, u0;
		longint e1[5], e2[5], g1[5], g2[5], g3[5];
		longint unsigned sy, su, d;
		bit adapt, lim;
		if (rst) reload_state();
		y0 = yp + OFFSET_180;
		y1 = ang_hist[0];
		y2 = ang_hist[1];
		u1 = drv_hist[0];
		u2 = drv_hist[1];
		u3 = drv_hist[2];
		u4 = drv_hist[3];
		yest = round_drop(est_par[0] * y1, 24) + round_drop(est_par[1] * y2, 24)
			+ round_drop(est_par[2] * u2, 24) + round_drop(est_par[3] * u3, 24)
			+ round_drop(est_par[4] * u4, 24);
		ek = y0 - yest;
		adapt = (ek > 13) || (ek < -13);
		if (adapt) begin
			sy = (longint'(y1 * y1) >> 16) + (longint'(y2 * y2) >> 16);
			su = (longint'(u2 * u2) >> 16) + (longint'(u3 * u3) >> 16)
				+ (longint'(u4 * u4) >> 16);
			d = 64'd65536 + ((sy * 64'd26214) >> 16) + ((su * 64'd13107) >> 16);
			ga = round_drop(ek * 26214, 16);
			gb = round_drop(ek * 13107, 16);
			est_par[0] = clip32(est_par[0] + grad_term(ga, y1, d));
			est_par[1] = clip32(est_par[1] + grad_term(ga, y2, d));
			est_par[2] = clip32(est_par[2] + grad_term(gb, u2, d));
			est_par[3] = clip32(est_par[3] + grad_term(gb, u3, d));
			est_par[4] = clip32(est_par[4] + grad_term(gb, u4, d));
		end
		ydk = round_drop(64'sd4004721 * yp - 64'sd1400344 * last_angle
			+ 64'sd14172838 * sp, 24) + OFFSET_180;
		e1[0] = est_par[0];
		e2[0] = est_par[1];
		g1[0] = est_par[2];
		g2[0] = est_par[3];
		g3[0] = est_par[4];
		for (int j = 1; j < 5; j++) begin
			e1[j] = clip32(round_drop(e1[j - 1] * e1[0], 24) + e2[j - 1]);
			e2[j] = clip32(round_drop(e1[j - 1] * e2[0], 24));
			g1[j] = clip32(round_drop(e1[j - 1] * g1[0], 24) + g2[j - 1]);
			g2[j] = clip32(round_drop(e1[j - 1] * g2[0], 24) + g3[j - 1]);
			g3[j] = clip32(round_drop(e1[j - 1] * g3[0], 24));
		end
		h = 0;
		for (int j = 0; j < 5; j++) h += g1[j];
		num = ydk - round_drop(e1[4] * y0, 24) - round_drop(e2[4] * y1, 24)
			- round_drop(g2[4] * u1, 24) - round_drop(g3[4] * u2, 24);
		lim = 1'b0;
		if (h == 0) begin
			// Zero horizon sum: saturate by the sign of the numerator.
			u0 = (num > 0) ? lim_drive : (num < 0) ? -lim_drive : 0;
			lim = (num != 0);
		end else begin
			u0 = (num * 64'sd16777216) / h;
			if (u0 > lim_drive) begin
				u0 = lim_drive;
				lim = 1'b1;
			end else if (u0 < -lim_drive) begin
				u0 = -lim_drive;
				lim = 1'b1;
			end
		end
		ang_hist[1] = y1;
		ang_hist[0] = y0;
		drv_hist[3] = u3;
		drv_hist[2] = u2;
		drv_hist[1] = u1;
		drv_hist[0] = u0;
		last_angle = yp;
		res.drive = drive_t'(u0);
		res.adapting = adapt;
		res.clamped = lim;
		return res;
	endfunction

	// Send one control period and queue its expected result on acceptance.
	task automatic send_period(row_t r);
		ctrl_out_t exp_out;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		measured_angle <= angle_t'(r.angle);
		setpoint <= angle_t'(r.target);
		restart <= r.rst;
		do @(posedge clk); while (!in_ready);
		exp_out = regulate(r.angle, r.target, r.rst);
		if (r.has_out) begin
			exp_out.drive = drive_t'(r.drive);
			exp_out.adapting = r.adapting;
			exp_out.clamped = r.clamped;
		end
		expected_q.push_back(exp_out);
	endtask

	// Register write; valid stays high so back-to-back writes need no gap.
	task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_cfg(idx, val);
	endtask

	task automatic write_all(cfg_data_t md, cfg_data_t a1, cfg_data_t a2, cfg_data_t b1,
			cfg_data_t b2, cfg_data_t b3);
		write_reg(REG_MAX_DRIVE, md);
		write_reg(REG_INIT_A1, a1);
		write_reg(REG_INIT_A2, a2);
		write_reg(REG_INIT_B1, b1);
		write_reg(REG_INIT_B2, b2);
		write_reg(REG_INIT_B3, b3);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Hold the sender until every expected result has been received.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic longint rand_angle();
		return longint'($urandom_range(23592960)) - ANGLE_MAX;
	endfunction

	function automatic cfg_data_t jitter(param_t base);
		return cfg_data_t'(base + param_t'($urandom_range(400000)) - 32'sd200000);
	endfunction

	// Result checker and receiver stalls.
	initial begin
		ctrl_out_t want;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected transaction: drive %0d", drive);
					err_count++;
				end else begin
					want = expected_q.pop_front();
					if (drive !== want.drive) begin
						$error("drive: expected %0d, got %0d", want.drive, drive);
						err_count++;
					end
					if (adapting !== want.adapting) begin
						$error("adapting: expected %0b, got %0b", want.adapting, adapting);
						err_count++;
					end
					if (clamped !== want.clamped) begin
						$error("clamped: expected %0b, got %0b", want.clamped, clamped);
						err_count++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Stimulus.
	initial begin
		row_t rows[$];
		row_t r;
		int idle_set[4][2];
		longint a, s;
		int seg_len;
		int sent;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MAX_DRIVE;
		cfg_data = '0;
		in_valid = 1'b0;
		measured_angle = '0;
		setpoint = '0;
		restart = 1'b0;
		err_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		idle_set = '{'{0, 0}, '{81, 0}, '{0, 81}, '{34, 34}};
		lim_drive = longint'(RST_MAX_DRIVE);
		seed_par = '{longint'(RST_INIT_A1), longint'(RST_INIT_A2), longint'(RST_INIT_B1),
			longint'(RST_INIT_B2), longint'(RST_INIT_B3)};
		reload_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: field extremes, checked by the predictor.
		rows = '{
			'{0, 0, 0, 0, 0, 0, 0},
			'{ANGLE_MAX, ANGLE_MAX, 0, 0, 0, 0, 0},
			'{-ANGLE_MAX, -ANGLE_MAX, 0, 0, 0, 0, 0},
			'{ANGLE_MAX, -ANGLE_MAX, 0, 0, 0, 0, 0},
			'{-ANGLE_MAX, ANGLE_MAX, 0, 0, 0, 0, 0},
			'{1, -1, 0, 0, 0, 0, 0},
			'{-1, 1, 1, 0, 0, 0, 0},
			'{0, 0, 1, 0, 0, 0, 0}
		};
		foreach (rows[i]) send_period(rows[i]);
		drain();

		// Zero model: horizon sum is zero, so the drive saturates by the numerator sign.
		write_all(32'h00FF_FFFF, 0, 0, 0, 0, 0);
		write_reg(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
		write_reg(REG_UNMAPPED_HI, 32'h1234_5678);
		cfg_valid <= 1'b0;
		rows = '{
			'{-ANGLE_MAX, ANGLE_MAX, 1, 1, 16777215, 0, 1},
			'{-ANGLE_MAX, -ANGLE_MAX, 1, 1, -16777215, 0, 1},
			'{-ANGLE_MAX, 0, 1, 0, 0, 0, 0},
			'{0, 0, 0, 0, 0, 0, 0}
		};
		foreach (rows[i]) send_period(rows[i]);
		drain();

		// Extreme parameters and a zero drive limit.
		write_all(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF);
		rows = '{
			'{0, 0, 1, 0, 0, 0, 0},
			'{ANGLE_MAX, 0, 0, 0, 0, 0, 0},
			'{-ANGLE_MAX, ANGLE_MAX, 0, 0, 0, 0, 0},
			'{ANGLE_MAX, -ANGLE_MAX, 1, 0, 0, 0, 0}
		};
		foreach (rows[i]) send_period(rows[i]);
		drain();

		// Random phases, each with its own settings and idling mix.
		for (int ph = 0; ph < 4; ph++) begin
			write_all(ph == 3 ? 32'h00FF_FFFF : cfg_data_t'($urandom_range(24'hFFFFFF)),
				jitter(RST_INIT_A1), jitter(RST_INIT_A2), jitter(RST_INIT_B1),
				jitter(RST_INIT_B2), ($urandom_range(3) == 0) ? cfg_data_t'($urandom())
					: jitter(RST_INIT_B3));
			send_idle_pct = idle_set[ph][0];
			recv_stall_pct = idle_set[ph][1];
			sent = 0;
			while (sent < 400) begin
				if ($urandom_range(4) == 0) begin
					// Noise: unrelated angles and targets.
					r = '{rand_angle(), rand_angle(), $urandom_range(15) == 0, 0, 0, 0, 0};
					send_period(r);
					sent++;
				end else begin
					// A tracking run: the angle wanders in small steps under a fixed target.
					seg_len = $urandom_range(40, 8);
					s = rand_angle();
					a = rand_angle();
					for (int k = 0; k < seg_len && sent < 400; k++) begin
						a = a + longint'($urandom_range(1310720)) - 64'sd655360;
						if (a > ANGLE_MAX) a = ANGLE_MAX;
						if (a < -ANGLE_MAX) a = -ANGLE_MAX;
						r = '{a, s, (k == 0) && ($urandom_range(3) == 0), 0, 0, 0, 0};
						send_period(r);
						sent++;
					end
				end
			end
			drain();
		end

		// Let any late result show up before the verdict.
		recv_stall_pct = 0;
		repeat (600) @(posedge clk);
		if (err_count == 0 && expected_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### filelist.f
design/apr_pkg.sv
design/adaptive_predictive_regulator.sv
design/apr_checker.sv
sim/tb_adaptive_predictive_regulator_core.sv
